FILE: rtl/hps_pkg.sv
// hps_pkg: phase codes, register indexes and reset values for the host power sequencer
// no dependencies; imported by host_power_sequencer
`default_nettype none

package hps_pkg;

  typedef enum logic [2:0] {
    PH_WAIT_ON   = 3'd0,
    PH_ON_DELAY  = 3'd1,
    PH_STARTUP   = 3'd2,
    PH_RUNNING   = 3'd3,
    PH_REBOOT    = 3'd4,
    PH_SHUTDOWN  = 3'd5,
    PH_OFF_DELAY = 3'd6,
    PH_OFF       = 3'd7
  } phase_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned StampW  = 32;

  localparam logic [CfgIdxW-1:0] CFG_SWITCH_DEBOUNCE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_DEBOUNCE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFF_DELAY       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ON_DELAY        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_HALF      = 3'd4;

  localparam logic [CfgW-1:0] RST_SWITCH_DEBOUNCE = 16'd2000;
  localparam logic [CfgW-1:0] RST_BUTTON_DEBOUNCE = 16'd500;
  localparam logic [CfgW-1:0] RST_OFF_DELAY       = 16'd5000;
  localparam logic [CfgW-1:0] RST_ON_DELAY        = 16'd7000;
  localparam logic [CfgW-1:0] RST_BLINK_HALF      = 16'd500;

  // request line drive enables and latched levels
  typedef struct packed {
    logic rb_lvl;
    logic rb_drv;
    logic sd_lvl;
    logic sd_drv;
  } req_lines_t;

  // wrapping elapsed time strictly above a limit
  function automatic logic elapsed_over(input logic [StampW-1:0] now,
                                        input logic [StampW-1:0] stamp,
                                        input logic [CfgW-1:0]   limit);
    logic [StampW-1:0] diff;
    diff = now - stamp;
    return diff > {{(StampW-CfgW){1'b0}}, limit};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/host_power_sequencer.sv
// host_power_sequencer: eight-state power sequencer for an attached host, one poll per request
// depends on hps_pkg (phase codes, register indexes, elapsed time compare)
//
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready| tdata: now_ms, switch, button, host_off
// m_axis    | out | m_axis_tvalid/m_axis_tready| tdata: relay, shutdown/reboot lines, led, phase
// cfg       | in  | cfg_we_i (always taken)    | cfg_index_i, cfg_data_i
//
// one request per clock sustained while results are not stalled; each poll is registered
// in the input register and evaluated against the state into the result register
// reset enters the off phase with led on, clears other state, loads default timing registers
// a stalled result holds the result register; the input register still takes one more poll
`default_nettype none

module host_power_sequencer import hps_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  // poll requests
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // [31:0] now_ms, [32] switch_level, [33] button_level, [34] host_off_level, [39:35] zero
  input  wire logic [39:0]        s_axis_tdata,
  // results
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [0] relay_on, [1] shutdown_driven, [2] shutdown_level, [3] reboot_driven,
  // [4] reboot_level, [5] led_level, [8:6] phase, [15:9] zero
  output logic [15:0]             m_axis_tdata
);

  // timing registers
  logic [CfgW-1:0] sw_deb_q, btn_deb_q, off_dly_q, on_dly_q, blink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_deb_q  <= RST_SWITCH_DEBOUNCE;
      btn_deb_q <= RST_BUTTON_DEBOUNCE;
      off_dly_q <= RST_OFF_DELAY;
      on_dly_q  <= RST_ON_DELAY;
      blink_q   <= RST_BLINK_HALF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SWITCH_DEBOUNCE: sw_deb_q  <= cfg_data_i;
        CFG_BUTTON_DEBOUNCE: btn_deb_q <= cfg_data_i;
        CFG_OFF_DELAY:       off_dly_q <= cfg_data_i;
        CFG_ON_DELAY:        on_dly_q  <= cfg_data_i;
        CFG_BLINK_HALF:      blink_q   <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // input register stage
  logic              in_valid_q;
  logic [StampW-1:0] now_q;
  logic              sw_q, btn_q, hoff_q;
  logic              fire;      // poll in the input register is evaluated this cycle
  logic              in_take;

  assign fire          = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q  <= s_axis_tdata[31:0];
      sw_q   <= s_axis_tdata[32];
      btn_q  <= s_axis_tdata[33];
      hoff_q <= s_axis_tdata[34];
    end
  end

  // sequencer state
  phase_e            phase_q, phase_d;
  logic              relay_q, relay_d;
  logic              led_q, led_d;
  req_lines_t        req_q, req_d;
  logic [StampW-1:0] led_stamp_q, led_stamp_d;
  logic [StampW-1:0] on_stamp_q, on_stamp_d;
  logic [StampW-1:0] off_stamp_q, off_stamp_d;
  logic [StampW-1:0] sw_stamp_q, sw_stamp_d;
  logic [StampW-1:0] btn_stamp_q, btn_stamp_d;

  // shared elapsed time checks
  logic blink_due, sw_due, btn_due, on_due, off_due;
  assign blink_due = elapsed_over(now_q, led_stamp_q, blink_q);
  assign sw_due    = elapsed_over(now_q, sw_stamp_q, sw_deb_q);
  assign btn_due   = elapsed_over(now_q, btn_stamp_q, btn_deb_q);
  assign on_due    = elapsed_over(now_q, on_stamp_q, on_dly_q);
  assign off_due   = elapsed_over(now_q, off_stamp_q, off_dly_q);

  // running state checks, in priority order (last one wins the phase)
  logic run_reboot, run_shutdown;
  assign run_reboot   = !btn_q && btn_due;
  assign run_shutdown = sw_q && sw_due;

  // blinking phases
  logic blinking;
  always_comb begin
    case (phase_q)
      PH_ON_DELAY, PH_STARTUP, PH_REBOOT, PH_SHUTDOWN, PH_OFF_DELAY: blinking = 1'b1;
      default: blinking = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_WAIT_ON:   if (!sw_q && sw_due) phase_d = PH_ON_DELAY;
      PH_ON_DELAY:  if (on_due) phase_d = PH_STARTUP;
      PH_STARTUP:   if (!hoff_q) phase_d = PH_RUNNING;
      PH_RUNNING: begin
        if (run_reboot)   phase_d = PH_REBOOT;
        if (run_shutdown) phase_d = PH_SHUTDOWN;
        if (hoff_q)       phase_d = PH_OFF_DELAY;
      end
      PH_REBOOT:    if (hoff_q) phase_d = PH_STARTUP;
      PH_SHUTDOWN:  if (hoff_q) phase_d = PH_OFF_DELAY;
      PH_OFF_DELAY: if (sw_q && off_due) phase_d = PH_OFF;
      PH_OFF:       phase_d = PH_WAIT_ON;
      default:      phase_d = PH_WAIT_ON;
    endcase
  end

  // relay, request lines, led and stamps
  always_comb begin
    relay_d     = relay_q;
    req_d       = req_q;
    led_d       = led_q;
    led_stamp_d = led_stamp_q;
    on_stamp_d  = on_stamp_q;
    off_stamp_d = off_stamp_q;
    sw_stamp_d  = sw_stamp_q;
    btn_stamp_d = btn_stamp_q;

    if (blinking && blink_due) begin
      led_d       = !led_q;
      led_stamp_d = now_q;
    end

    case (phase_q)
      PH_WAIT_ON: begin
        if (!sw_q && sw_due) begin
          req_d.sd_drv = 1'b0;
          req_d.rb_drv = 1'b0;
          relay_d      = 1'b1;
          sw_stamp_d   = now_q;
          on_stamp_d   = now_q;
        end
      end
      PH_ON_DELAY: begin
        if (on_due) req_d = '{rb_lvl: 1'b1, rb_drv: 1'b1, sd_lvl: 1'b1, sd_drv: 1'b1};
      end
      PH_STARTUP: begin
        // the running state shows the led steady off
        if (!hoff_q) led_d = 1'b0;
      end
      PH_RUNNING: begin
        if (run_reboot) begin
          req_d.rb_lvl = 1'b0;
          btn_stamp_d  = now_q;
        end
        if (run_shutdown) begin
          req_d.sd_lvl = 1'b0;
          sw_stamp_d   = now_q;
        end
        if (hoff_q) off_stamp_d = now_q;
      end
      PH_REBOOT: begin
        if (hoff_q) req_d.rb_drv = 1'b0;
      end
      PH_SHUTDOWN: begin
        if (hoff_q) begin
          req_d.sd_drv = 1'b0;
          off_stamp_d  = now_q;
        end
      end
      PH_OFF_DELAY: begin
        if (sw_q && off_due) sw_stamp_d = now_q;
      end
      default: begin
        // off: drop the relay, release both lines, led on, latches stay
        relay_d      = 1'b0;
        req_d.sd_drv = 1'b0;
        req_d.rb_drv = 1'b0;
        led_d        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OFF;
      relay_q     <= 1'b0;
      led_q       <= 1'b1;
      req_q       <= '0;
      led_stamp_q <= '0;
      on_stamp_q  <= '0;
      off_stamp_q <= '0;
      sw_stamp_q  <= '0;
      btn_stamp_q <= '0;
    end else if (fire) begin
      phase_q     <= phase_d;
      relay_q     <= relay_d;
      led_q       <= led_d;
      req_q       <= req_d;
      led_stamp_q <= led_stamp_d;
      on_stamp_q  <= on_stamp_d;
      off_stamp_q <= off_stamp_d;
      sw_stamp_q  <= sw_stamp_d;
      btn_stamp_q <= btn_stamp_d;
    end
  end

  // result register
  logic [15:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {7'd0, phase_d, led_d, req_d.rb_lvl, req_d.rb_drv,
                     req_d.sd_lvl, req_d.sd_drv, relay_d};
    end
  end

  assign m_axis_tdata = out_data_q;

`ifndef SYNTHESIS
  // relay is never energized while waiting for the switch
  a_wait_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT_ON) |-> !relay_q)
    else $error("relay energized in wait-on phase");

  // a poll in the input stage is held until it is evaluated
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> in_valid_q)
    else $error("input stage dropped a poll");

  // every evaluated poll shows up as a result
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("evaluated poll produced no result");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking bench for host_power_sequencer, a stream of timestamped polls in,
// one status word out per poll, checked against a built-in model of the sequencer
// depends on hps_pkg (phase codes, register indexes, request line struct) and the rtl
`timescale 1ns / 1ps

module tb;
  import hps_pkg::*;

  // one poll as packed in s_axis_tdata, highest field first
  typedef struct packed {
    logic        host_off;
    logic        button;
    logic        switch_lvl;
    logic [31:0] now_ms;
  } poll_t;

  // status word as packed in m_axis_tdata[8:0]
  typedef struct packed {
    phase_e phase;
    logic   led;
    logic   rb_lvl;
    logic   rb_drv;
    logic   sd_lvl;
    logic   sd_drv;
    logic   relay;
  } status_t;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // [31:0] now_ms, [32] switch_level, [33] button_level, [34] host_off_level, [39:35] zero
  logic [39:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [0] relay_on, [1] shutdown_driven, [2] shutdown_level, [3] reboot_driven,
  // [4] reboot_level, [5] led_level, [8:6] phase, [15:9] zero
  logic [15:0]        m_axis_tdata;

  host_power_sequencer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // polls waiting for the driver, and status words the sequencer still owes us
  poll_t   poll_q[$];
  status_t expected_status_q[$];
  int unsigned mismatch_count = 0;
  bit steady = 1'b0;  // when set neither side inserts bubbles

  // ---------------------------------------------------------------------------
  // sequencer model: timing registers and state, updated per accepted poll
  // ---------------------------------------------------------------------------
  logic [15:0] sw_debounce, btn_debounce, off_wait, on_wait, blink_half;
  phase_e      ph;
  logic        relay, led;
  req_lines_t  lines;
  logic [31:0] led_stamp, on_stamp, off_stamp, switch_stamp, button_stamp;

  function automatic void reset_model();
    sw_debounce  = RST_SWITCH_DEBOUNCE;
    btn_debounce = RST_BUTTON_DEBOUNCE;
    off_wait     = RST_OFF_DELAY;
    on_wait      = RST_ON_DELAY;
    blink_half   = RST_BLINK_HALF;
    ph           = PH_OFF;
    relay        = 1'b0;
    led          = 1'b1;
    lines        = '0;
    led_stamp    = '0;
    on_stamp     = '0;
    off_stamp    = '0;
    switch_stamp = '0;
    button_stamp = '0;
  endfunction

  // elapsed time modulo 2^32, strictly longer than the limit
  function automatic bit waited_past(logic [31:0] now, logic [31:0] stamp,
                                     logic [15:0] limit);
    logic [31:0] span;
    span = now - stamp;
    return span > {16'd0, limit};
  endfunction

  function automatic void blink_led(logic [31:0] now);
    if (waited_past(now, led_stamp, blink_half)) begin
      led       = ~led;
      led_stamp = now;
    end
  endfunction

  function automatic status_t advance_sequencer(poll_t p);
    status_t s;
    case (ph)
      PH_WAIT_ON: begin
        if (!p.switch_lvl && waited_past(p.now_ms, switch_stamp, sw_debounce)) begin
          lines.sd_drv = 1'b0;
          lines.rb_drv = 1'b0;
          ph           = PH_ON_DELAY;
          relay        = 1'b1;
          switch_stamp = p.now_ms;
          on_stamp     = p.now_ms;
        end
      end
      PH_ON_DELAY: begin
        blink_led(p.now_ms);
        if (waited_past(p.now_ms, on_stamp, on_wait)) begin
          lines = '1;
          ph    = PH_STARTUP;
        end
      end
      PH_STARTUP: begin
        blink_led(p.now_ms);
        if (!p.host_off) begin
          led = 1'b0;
          ph  = PH_RUNNING;
        end
      end
      PH_RUNNING: begin
        // reboot, then shutdown, then host off; later checks override the phase
        if (!p.button && waited_past(p.now_ms, button_stamp, btn_debounce)) begin
          ph           = PH_REBOOT;
          lines.rb_lvl = 1'b0;
          button_stamp = p.now_ms;
        end
        if (p.switch_lvl && waited_past(p.now_ms, switch_stamp, sw_debounce)) begin
          ph           = PH_SHUTDOWN;
          lines.sd_lvl = 1'b0;
          switch_stamp = p.now_ms;
        end
        if (p.host_off) begin
          ph        = PH_OFF_DELAY;
          off_stamp = p.now_ms;
        end
      end
      PH_REBOOT: begin
        blink_led(p.now_ms);
        if (p.host_off) begin
          lines.rb_drv = 1'b0;
          ph           = PH_STARTUP;
        end
      end
      PH_SHUTDOWN: begin
        blink_led(p.now_ms);
        if (p.host_off) begin
          lines.sd_drv = 1'b0;
          ph           = PH_OFF_DELAY;
          off_stamp    = p.now_ms;
        end
      end
      PH_OFF_DELAY: begin
        blink_led(p.now_ms);
        if (p.switch_lvl && waited_past(p.now_ms, off_stamp, off_wait)) begin
          ph           = PH_OFF;
          switch_stamp = p.now_ms;
        end
      end
      default: begin
        // off: drop the relay, release both lines, led on, latches untouched
        relay        = 1'b0;
        lines.sd_drv = 1'b0;
        lines.rb_drv = 1'b0;
        led          = 1'b1;
        ph           = PH_WAIT_ON;
      end
    endcase
    s.relay  = relay;
    s.sd_drv = lines.sd_drv;
    s.sd_lvl = lines.sd_lvl;
    s.rb_drv = lines.rb_drv;
    s.rb_lvl = lines.rb_lvl;
    s.led    = led;
    s.phase  = ph;
    return s;
  endfunction

  // random bubble on either side, taken with a chance of about 31 in a hundred unless steady
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 31);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued polls, runs them through the model on acceptance
  // ---------------------------------------------------------------------------
  poll_t cur_poll;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_status_q.push_back(advance_sequencer(cur_poll));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (poll_q.size() != 0 && !take_break()) begin
          cur_poll = poll_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'd0, cur_poll};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each status word against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  status_t got_status, want_status;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = status_t'(m_axis_tdata[8:0]);
        if (expected_status_q.size() == 0) begin
          $display("%0t: status with no poll pending, expected none, got %h",
                   $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want_status = expected_status_q.pop_front();
          check_field("relay_on", 32'(want_status.relay), 32'(got_status.relay));
          check_field("shutdown_driven", 32'(want_status.sd_drv), 32'(got_status.sd_drv));
          check_field("shutdown_level", 32'(want_status.sd_lvl), 32'(got_status.sd_lvl));
          check_field("reboot_driven", 32'(want_status.rb_drv), 32'(got_status.rb_drv));
          check_field("reboot_level", 32'(want_status.rb_lvl), 32'(got_status.rb_lvl));
          check_field("led_level", 32'(want_status.led), 32'(got_status.led));
          check_field("phase", 32'(want_status.phase), 32'(got_status.phase));
        end
      end
      m_axis_tready <= !take_break();
    end
  end

  // watchdog: too long without any request moving on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [31:0] gen_now;
  logic        gen_sw, gen_btn, gen_hoff;

  function automatic void push_poll(logic [31:0] now, logic sw, logic btn, logic hoff);
    poll_t p;
    p.now_ms     = now;
    p.switch_lvl = sw;
    p.button     = btn;
    p.host_off   = hoff;
    poll_q.push_back(p);
  endfunction

  // levels hold for stretches and flip now and then, so the switch, button and
  // host off sequences walk the whole state graph; time mostly creeps forward
  // with the odd jump anywhere, backwards included
  function automatic void random_polls(int unsigned count, int unsigned max_step);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) gen_sw   = ~gen_sw;
      if ($urandom_range(99) < 8) gen_btn  = ~gen_btn;
      if ($urandom_range(99) < 8) gen_hoff = ~gen_hoff;
      if ($urandom_range(99) < 3)
        gen_now = $urandom;
      else
        gen_now = gen_now + $urandom_range(max_step);
      push_poll(gen_now, gen_sw, gen_btn, gen_hoff);
    end
  endfunction

  // block is idle once nothing is queued, presented or owed
  task automatic wait_drained();
    while (poll_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      CFG_SWITCH_DEBOUNCE: sw_debounce  = value;
      CFG_BUTTON_DEBOUNCE: btn_debounce = value;
      CFG_OFF_DELAY:       off_wait     = value;
      CFG_ON_DELAY:        on_wait      = value;
      CFG_BLINK_HALF:      blink_half   = value;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [15:0] sw_ms, logic [15:0] btn_ms, logic [15:0] off_ms,
                            logic [15:0] on_ms, logic [15:0] blink_ms);
    wait_drained();
    write_reg(CFG_SWITCH_DEBOUNCE, sw_ms);
    write_reg(CFG_BUTTON_DEBOUNCE, btn_ms);
    write_reg(CFG_OFF_DELAY, off_ms);
    write_reg(CFG_ON_DELAY, on_ms);
    write_reg(CFG_BLINK_HALF, blink_ms);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    reset_model();
    gen_now  = '0;
    gen_sw   = 1'b1;
    gen_btn  = 1'b1;
    gen_hoff = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed walk at the reset timing values
    push_poll(32'd0, 1'b1, 1'b1, 1'b1);        // off to wait-on
    push_poll(32'd100, 1'b0, 1'b1, 1'b1);      // switch on, debounce not yet over
    push_poll(32'd2001, 1'b0, 1'b1, 1'b1);     // relay on
    push_poll(32'd9001, 1'b0, 1'b1, 1'b1);     // on delay exactly reached, not past
    push_poll(32'd9002, 1'b0, 1'b1, 1'b1);     // lines driven high
    push_poll(32'd9003, 1'b0, 1'b1, 1'b1);     // host still off
    push_poll(32'd9004, 1'b0, 1'b1, 1'b0);     // running
    push_poll(32'd20000, 1'b1, 1'b0, 1'b1);    // all three checks on one poll
    push_poll(32'd25000, 1'b1, 1'b1, 1'b1);    // off delay exactly reached
    push_poll(32'd25001, 1'b1, 1'b1, 1'b1);    // off
    push_poll(32'd25002, 1'b0, 1'b0, 1'b0);    // wait-on, lines released
    push_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1); // relay on at the top of the clock
    push_poll(32'd7000, 1'b0, 1'b1, 1'b1);     // on delay past across the wrap
    push_poll(32'd7001, 1'b0, 1'b1, 1'b0);     // running
    push_poll(32'd7100, 1'b0, 1'b0, 1'b0);     // reboot, button stamp lies ahead
    push_poll(32'd7200, 1'b0, 1'b1, 1'b1);     // host off: reboot line released
    push_poll(32'd7300, 1'b0, 1'b1, 1'b0);     // running again
    push_poll(32'd7400, 1'b1, 1'b1, 1'b0);     // shutdown request
    push_poll(32'd7500, 1'b1, 1'b1, 1'b1);     // shutdown line released
    push_poll(32'd20000, 1'b0, 1'b1, 1'b1);    // switch back on holds off delay
    push_poll(32'd20001, 1'b1, 1'b1, 1'b1);    // off
    push_poll(32'd20002, 1'b1, 1'b1, 1'b1);    // wait-on
    push_poll(32'd20003, 1'b0, 1'b1, 1'b1);    // switch stamp 20001: debounce not over
    gen_now = 32'd20003;

    // short timings, no bubbles on either side
    set_timing(16'($urandom_range(40)), 16'($urandom_range(40)), 16'($urandom_range(40)),
               16'($urandom_range(40)), 16'($urandom_range(40)));
    steady = 1'b1;
    random_polls(200, 30);
    wait_drained();
    steady = 1'b0;

    // zero timings: any forward step satisfies every wait
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_polls(150, 3);

    // longest timings with large steps
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_polls(150, 40000);

    // mixed moderate timings
    set_timing(16'($urandom_range(200)), 16'($urandom_range(200)), 16'($urandom_range(200)),
               16'($urandom_range(200)), 16'($urandom_range(200)));
    random_polls(300, 100);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
